// File: rtl/hrlp_pkg.sv
// Package for the HTTP request line parser: status and method codes,
// character constants and the result record. No dependencies.
package hrlp_pkg;

  typedef enum logic [2:0] {
    ST_PROGRESS    = 3'd0,
    ST_DONE        = 3'd1,
    ST_BAD_REQUEST = 3'd2,
    ST_BAD_METHOD  = 3'd3,
    ST_TOO_LONG    = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    M_GET     = 2'd0,
    M_HEAD    = 2'd1,
    M_POST    = 2'd2,
    M_UNKNOWN = 2'd3
  } method_e;

  localparam int unsigned DATA_W    = 8;
  localparam int unsigned VER_W     = 10;
  localparam int unsigned OUT_OFS_W = 16;
  localparam int unsigned LEN_W     = 16;

  localparam logic [VER_W-1:0] VER_MAX = 10'd999;

  // configuration register map
  localparam int unsigned APB_ADDR_W = 3;
  localparam int unsigned REG_IDX_W  = 1;
  localparam logic [REG_IDX_W-1:0] REG_MAX_LINE_LEN = 1'b0;
  localparam logic [LEN_W-1:0] MAX_LINE_LEN_RST = 16'd8192;

  localparam logic [7:0] CH_LF    = 8'd10;
  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_SP    = 8'd32;
  localparam logic [7:0] CH_SLASH = "/";
  localparam logic [7:0] CH_DOT   = ".";
  localparam logic [7:0] CH_0     = "0";
  localparam logic [7:0] CH_9     = "9";
  localparam logic [7:0] CH_A     = "A";
  localparam logic [7:0] CH_Z     = "Z";
  localparam logic [7:0] CH_D     = "D";
  localparam logic [7:0] CH_E     = "E";
  localparam logic [7:0] CH_G     = "G";
  localparam logic [7:0] CH_H     = "H";
  localparam logic [7:0] CH_O     = "O";
  localparam logic [7:0] CH_P     = "P";
  localparam logic [7:0] CH_S     = "S";
  localparam logic [7:0] CH_T     = "T";

  localparam logic [31:0] WORD_GET  = {8'd0, CH_G, CH_E, CH_T};
  localparam logic [31:0] WORD_HEAD = {CH_H, CH_E, CH_A, CH_D};
  localparam logic [31:0] WORD_POST = {CH_P, CH_O, CH_S, CH_T};

  // last field (status) in the lowest bits
  typedef struct packed {
    logic [OUT_OFS_W-1:0] line_end;
    logic [OUT_OFS_W-1:0] uri_end;
    logic [OUT_OFS_W-1:0] uri_start;
    logic [VER_W-1:0]     minor_version;
    logic [VER_W-1:0]     major_version;
    method_e              method_code;
    status_e              status;
  } result_t;

  localparam int unsigned OUT_TDATA_W = 80;

endpackage

// File: rtl/hrlp_cfg.sv
// APB register block for the request line parser: holds max_line_length.
// Depends on hrlp_pkg.
module hrlp_cfg (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [hrlp_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [31:0]                      pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready,
  output logic [hrlp_pkg::LEN_W-1:0]       max_len_o
);

  logic [hrlp_pkg::LEN_W-1:0]     max_len_q;
  logic [hrlp_pkg::REG_IDX_W-1:0] reg_idx;
  logic                           wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[hrlp_pkg::APB_ADDR_W-1:2];
  assign wr_en   = psel && penable && pwrite && (reg_idx == hrlp_pkg::REG_MAX_LINE_LEN);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q <= hrlp_pkg::MAX_LINE_LEN_RST;
    end else if (wr_en) begin
      max_len_q <= pwdata[hrlp_pkg::LEN_W-1:0];
    end
  end

  always_comb begin
    unique case (reg_idx)
      hrlp_pkg::REG_MAX_LINE_LEN: prdata = {{(32-hrlp_pkg::LEN_W){1'b0}}, max_len_q};
      default:                    prdata = 32'd0;
    endcase
  end

  assign max_len_o = max_len_q;

endmodule

// File: rtl/hrlp_core.sv
// Parse state machine and field capture for one request byte per cycle while en_i is high.
// Produces the result record combinationally; depends on hrlp_pkg.
module hrlp_core #(
  parameter int unsigned OFFSET_BITS = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         en_i,
  input  logic [hrlp_pkg::DATA_W-1:0]  byte_i,
  input  logic [hrlp_pkg::LEN_W-1:0]   max_len_i,
  output hrlp_pkg::result_t            result_o
);

  localparam int unsigned EXT_W =
    (OFFSET_BITS > hrlp_pkg::LEN_W) ? OFFSET_BITS : hrlp_pkg::LEN_W;

  typedef enum logic [3:0] {
    PS_START, PS_METHOD, PS_SP_URI, PS_URI, PS_SP_HTTP, PS_H, PS_HT, PS_HTT,
    PS_HTTP, PS_MAJ1, PS_MAJ, PS_MIN1, PS_MIN, PS_SP_END, PS_ALMOST
  } pstate_e;

  pstate_e                        st_q, st_d;
  logic [OFFSET_BITS-1:0]         off_q, off_d;
  logic [31:0]                    let_q, let_d;
  logic [2:0]                     len_q, len_d;
  logic [hrlp_pkg::VER_W-1:0]     maj_q, maj_d;
  logic [hrlp_pkg::VER_W-1:0]     min_q, min_d;
  logic [OFFSET_BITS-1:0]         us_q, us_d;
  logic [OFFSET_BITS-1:0]         ue_q, ue_d;
  logic [OFFSET_BITS-1:0]         le_q, le_d;

  hrlp_pkg::status_e              sts;
  hrlp_pkg::method_e              meth;
  logic                           skip;
  logic                           too_long;
  logic                           is_dig;
  logic                           is_up;
  logic [3:0]                     dig;
  logic [EXT_W-1:0]               off_ext, max_ext, us_ext, ue_ext, le_ext;

  function automatic logic [hrlp_pkg::VER_W-1:0] add_digit(
    input logic [hrlp_pkg::VER_W-1:0] v,
    input logic [3:0]                 d
  );
    logic [13:0] n;
    n = {v, 3'b000} + {3'b000, v, 1'b0} + {10'd0, d};
    add_digit = (n > 14'(hrlp_pkg::VER_MAX)) ? hrlp_pkg::VER_MAX : n[hrlp_pkg::VER_W-1:0];
  endfunction

  assign is_dig  = (byte_i >= hrlp_pkg::CH_0) && (byte_i <= hrlp_pkg::CH_9);
  assign is_up   = (byte_i >= hrlp_pkg::CH_A) && (byte_i <= hrlp_pkg::CH_Z);
  assign dig     = 4'(byte_i - hrlp_pkg::CH_0);
  assign off_ext = EXT_W'(off_q);
  assign max_ext = EXT_W'(max_len_i);
  // limit check happens before the byte is parsed
  assign too_long = (off_ext > max_ext) || (&off_q);

  always_comb begin
    st_d  = st_q;
    off_d = off_q;
    let_d = let_q;
    len_d = len_q;
    maj_d = maj_q;
    min_d = min_q;
    us_d  = us_q;
    ue_d  = ue_q;
    le_d  = le_q;
    sts   = hrlp_pkg::ST_PROGRESS;
    skip  = 1'b0;

    if (too_long) begin
      sts = hrlp_pkg::ST_TOO_LONG;
    end else begin
      unique case (st_q)
        PS_START: begin
          if (byte_i == hrlp_pkg::CH_CR || byte_i == hrlp_pkg::CH_LF ||
              byte_i == hrlp_pkg::CH_SP) begin
            skip = 1'b1;
          end else if (!is_up) begin
            sts = hrlp_pkg::ST_BAD_REQUEST;
          end else begin
            let_d = {let_q[23:0], byte_i};
            len_d = 3'd1;
            st_d  = PS_METHOD;
          end
        end
        PS_METHOD: begin
          if (byte_i == hrlp_pkg::CH_SP) begin
            st_d = PS_SP_URI;
          end else if (is_up) begin
            // keep the first four letters; length saturates at five
            if (len_q < 3'd4) let_d = {let_q[23:0], byte_i};
            if (len_q < 3'd5) len_d = len_q + 3'd1;
          end else begin
            sts = hrlp_pkg::ST_BAD_METHOD;
          end
        end
        PS_SP_URI: begin
          if (byte_i == hrlp_pkg::CH_SLASH) begin
            us_d = off_q + 1'b1;
            st_d = PS_URI;
          end else if (byte_i != hrlp_pkg::CH_SP) begin
            sts = hrlp_pkg::ST_BAD_REQUEST;
          end
        end
        PS_URI: begin
          if (byte_i == hrlp_pkg::CH_SP) begin
            ue_d = off_q;
            st_d = PS_SP_HTTP;
          end
        end
        PS_SP_HTTP: begin
          if (byte_i == hrlp_pkg::CH_H) st_d = PS_H;
          else if (byte_i != hrlp_pkg::CH_SP) sts = hrlp_pkg::ST_BAD_REQUEST;
        end
        PS_H: begin
          if (byte_i == hrlp_pkg::CH_T) st_d = PS_HT;
          else sts = hrlp_pkg::ST_BAD_REQUEST;
        end
        PS_HT: begin
          if (byte_i == hrlp_pkg::CH_T) st_d = PS_HTT;
          else sts = hrlp_pkg::ST_BAD_REQUEST;
        end
        PS_HTT: begin
          if (byte_i == hrlp_pkg::CH_P) st_d = PS_HTTP;
          else sts = hrlp_pkg::ST_BAD_REQUEST;
        end
        PS_HTTP: begin
          if (byte_i == hrlp_pkg::CH_SLASH) st_d = PS_MAJ1;
          else sts = hrlp_pkg::ST_BAD_REQUEST;
        end
        PS_MAJ1: begin
          if (is_dig) begin
            maj_d = hrlp_pkg::VER_W'(dig);
            st_d  = PS_MAJ;
          end else begin
            sts = hrlp_pkg::ST_BAD_REQUEST;
          end
        end
        PS_MAJ: begin
          if (byte_i == hrlp_pkg::CH_DOT) st_d = PS_MIN1;
          else if (is_dig) maj_d = add_digit(maj_q, dig);
          else sts = hrlp_pkg::ST_BAD_REQUEST;
        end
        PS_MIN1: begin
          if (is_dig) begin
            min_d = hrlp_pkg::VER_W'(dig);
            st_d  = PS_MIN;
          end else begin
            sts = hrlp_pkg::ST_BAD_REQUEST;
          end
        end
        PS_MIN, PS_SP_END: begin
          if (byte_i == hrlp_pkg::CH_SP) begin
            st_d = PS_SP_END;
          end else if (byte_i == hrlp_pkg::CH_CR) begin
            le_d = off_q;
            st_d = PS_ALMOST;
          end else if (byte_i == hrlp_pkg::CH_LF) begin
            le_d = off_q;
            sts  = hrlp_pkg::ST_DONE;
          end else if (st_q == PS_MIN && is_dig) begin
            min_d = add_digit(min_q, dig);
          end else begin
            sts = hrlp_pkg::ST_BAD_REQUEST;
          end
        end
        PS_ALMOST: begin
          if (byte_i == hrlp_pkg::CH_LF) sts = hrlp_pkg::ST_DONE;
          else sts = hrlp_pkg::ST_BAD_REQUEST;
        end
        default: sts = hrlp_pkg::ST_BAD_REQUEST;
      endcase
    end

    if (len_d == 3'd3 && let_d == hrlp_pkg::WORD_GET) begin
      meth = hrlp_pkg::M_GET;
    end else if (len_d == 3'd4 && let_d == hrlp_pkg::WORD_HEAD) begin
      meth = hrlp_pkg::M_HEAD;
    end else if (len_d == 3'd4 && let_d == hrlp_pkg::WORD_POST) begin
      meth = hrlp_pkg::M_POST;
    end else begin
      meth = hrlp_pkg::M_UNKNOWN;
    end

    us_ext = EXT_W'(us_d);
    ue_ext = EXT_W'(ue_d);
    le_ext = EXT_W'(le_d);

    result_o        = '0;
    result_o.status = sts;
    if (sts == hrlp_pkg::ST_DONE) begin
      result_o.method_code   = meth;
      result_o.major_version = maj_d;
      result_o.minor_version = min_d;
      result_o.uri_start     = us_ext[hrlp_pkg::OUT_OFS_W-1:0];
      result_o.uri_end       = ue_ext[hrlp_pkg::OUT_OFS_W-1:0];
      result_o.line_end      = le_ext[hrlp_pkg::OUT_OFS_W-1:0];
    end

    // any final status returns the parser to its start
    if (sts != hrlp_pkg::ST_PROGRESS) begin
      st_d  = PS_START;
      off_d = '0;
      let_d = '0;
      len_d = '0;
      maj_d = '0;
      min_d = '0;
      us_d  = '0;
      ue_d  = '0;
      le_d  = '0;
    end else if (!skip) begin
      off_d = off_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= PS_START;
      off_q <= '0;
      let_q <= '0;
      len_q <= '0;
      maj_q <= '0;
      min_q <= '0;
      us_q  <= '0;
      ue_q  <= '0;
      le_q  <= '0;
    end else if (en_i) begin
      st_q  <= st_d;
      off_q <= off_d;
      let_q <= let_d;
      len_q <= len_d;
      maj_q <= maj_d;
      min_q <= min_d;
      us_q  <= us_d;
      ue_q  <= ue_d;
      le_q  <= le_d;
    end
  end

`ifndef NO_ASSERTIONS
  a_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en_i && (sts != hrlp_pkg::ST_PROGRESS) |=> (st_q == PS_START) && (off_q == '0))
    else $error("parser did not restart after final status");
  a_start_off: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == PS_START) |-> (off_q == '0) && (len_q == 3'd0))
    else $error("start state with nonzero offset or method length");
  a_ver_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (maj_q <= hrlp_pkg::VER_MAX) && (min_q <= hrlp_pkg::VER_MAX))
    else $error("version count above saturation limit");
  a_not_done_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_o.status != hrlp_pkg::ST_DONE) |->
      (result_o.major_version == '0) && (result_o.line_end == '0))
    else $error("fields set on a result that is not done");
`endif

endmodule

// File: rtl/http_request_line_parser.sv
// HTTP/1.x request line parser: one input byte per cycle while the output is not stalled, one status per byte.
// Result path: an accepted byte is held in the input register, then its result goes to the result register.
// Throughput: one byte per cycle while m_axis_tready holds; a stalled output holds the input register.
// Reset (rst_ni, async, active low): parser at start, offset 0, max_line_length 8192,
// both pipeline registers empty. Depends on hrlp_pkg, hrlp_cfg, hrlp_core.
module http_request_line_parser #(
  parameter int unsigned OFFSET_BITS = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  logic [hrlp_pkg::DATA_W-1:0]          s_axis_tdata,  // [7:0] data_byte
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // [2:0] status, [4:3] method_code, [14:5] major_version, [24:15] minor_version,
  // [40:25] uri_start, [56:41] uri_end, [72:57] line_end, [79:73] zero
  output logic [hrlp_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [hrlp_pkg::APB_ADDR_W-1:0]      paddr,
  input  logic [31:0]                          pwdata,
  output logic [31:0]                          prdata,
  output logic                                 pready
);

  localparam int unsigned PAD_W = hrlp_pkg::OUT_TDATA_W - $bits(hrlp_pkg::result_t);

  logic                          in_valid_q;
  logic [hrlp_pkg::DATA_W-1:0]   in_byte_q;
  logic                          out_valid_q;
  hrlp_pkg::result_t             out_q;
  hrlp_pkg::result_t             res;
  logic [hrlp_pkg::LEN_W-1:0]    max_len;
  logic                          advance;

  hrlp_cfg u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .max_len_o (max_len)
  );

  hrlp_core #(
    .OFFSET_BITS (OFFSET_BITS)
  ) u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (advance),
    .byte_i    (in_byte_q),
    .max_len_i (max_len),
    .result_o  (res)
  );

  // byte moves from the input register to the result register
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_axis_tready) in_valid_q <= s_axis_tvalid;
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) in_byte_q <= s_axis_tdata;
    if (advance) out_q <= res;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{PAD_W{1'b0}}, out_q};

`ifndef NO_ASSERTIONS
  a_in_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> in_valid_q)
    else $error("accepted byte not held in input register");
  a_adv_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_q)
    else $error("parsed byte did not produce a result");
  a_no_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !m_axis_tready && !in_valid_q |=> out_valid_q)
    else $error("pending result dropped");
`endif

endmodule

// File: tb/sv/http_request_line_parser_tb.sv
// Testbench for http_request_line_parser: byte stream in, one status record out per byte.
// Predicts every record with its own parser model and checks it field by field.
// Depends on hrlp_pkg and the http_request_line_parser RTL.
module http_request_line_parser_tb;

  localparam int unsigned OFS_W       = 16;
  localparam int unsigned HOLD_CYCLES = 150;
  localparam int unsigned TX_DEPTH    = 32;
  localparam logic [hrlp_pkg::APB_ADDR_W-1:0] MAX_LEN_ADDR =
    {hrlp_pkg::REG_MAX_LINE_LEN, 2'b00};

  typedef enum logic [3:0] {
    PS_LEAD, PS_METHOD, PS_PRE_URI, PS_URI, PS_PRE_PROTO, PS_H, PS_HT, PS_HTT, PS_HTTP,
    PS_MAJ_FIRST, PS_MAJ, PS_MIN_FIRST, PS_MIN, PS_TRAIL, PS_CR
  } parse_e;

  class request_line_scoreboard;
    logic [hrlp_pkg::LEN_W-1:0]     max_len;
    parse_e                         state;
    logic [hrlp_pkg::OUT_OFS_W-1:0] offset;
    logic [hrlp_pkg::OUT_OFS_W-1:0] uri_s;
    logic [hrlp_pkg::OUT_OFS_W-1:0] uri_e;
    logic [hrlp_pkg::OUT_OFS_W-1:0] line_e;
    logic [31:0]                    letters;
    int unsigned                    n_letters;
    logic [hrlp_pkg::VER_W-1:0]     major;
    logic [hrlp_pkg::VER_W-1:0]     minor;
    bit                             cr_seen;
    hrlp_pkg::result_t              expected_q[$];
    int unsigned                    accepted;
    int unsigned                    checked;
    int unsigned                    errors;
    int unsigned                    status_seen[5];

    function new();
      max_len = hrlp_pkg::MAX_LINE_LEN_RST;
      restart();
    endfunction

    function void restart();
      state     = PS_LEAD;
      offset    = '0;
      uri_s     = '0;
      uri_e     = '0;
      line_e    = '0;
      letters   = '0;
      n_letters = 0;
      major     = '0;
      minor     = '0;
      cr_seen   = 1'b0;
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    function void fail(string msg);
      errors++;
      if (errors <= 10) $display("MISMATCH: %s", msg);
    endfunction

    function bit is_upper(logic [7:0] c);
      return c >= hrlp_pkg::CH_A && c <= hrlp_pkg::CH_Z;
    endfunction

    function bit is_digit(logic [7:0] c);
      return c >= hrlp_pkg::CH_0 && c <= hrlp_pkg::CH_9;
    endfunction

    function logic [hrlp_pkg::VER_W-1:0] add_digit(logic [hrlp_pkg::VER_W-1:0] v,
                                                   logic [7:0] c);
      int unsigned n;
      n = v * 10 + (c - hrlp_pkg::CH_0);
      return (n > hrlp_pkg::VER_MAX) ? hrlp_pkg::VER_MAX : n[hrlp_pkg::VER_W-1:0];
    endfunction

    function void add_letter(logic [7:0] c);
      if (n_letters < 4) letters = {letters[23:0], c};
      if (n_letters < 5) n_letters++;
    endfunction

    function hrlp_pkg::method_e method_of();
      if (n_letters == 3 && letters == hrlp_pkg::WORD_GET) return hrlp_pkg::M_GET;
      if (n_letters == 4 && letters == hrlp_pkg::WORD_HEAD) return hrlp_pkg::M_HEAD;
      if (n_letters == 4 && letters == hrlp_pkg::WORD_POST) return hrlp_pkg::M_POST;
      return hrlp_pkg::M_UNKNOWN;
    endfunction

    function string show(hrlp_pkg::result_t r);
      return $sformatf("status=%0d method=%0d ver=%0d.%0d uri=%0d..%0d end=%0d",
                       r.status, r.method_code, r.major_version, r.minor_version,
                       r.uri_start, r.uri_end, r.line_end);
    endfunction

    // one accepted input byte -> one expected record
    function void note_byte(logic [7:0] c);
      hrlp_pkg::status_e              st;
      hrlp_pkg::result_t              want;
      logic [hrlp_pkg::OUT_OFS_W-1:0] off;
      bit                             counted;
      off     = offset;
      st      = hrlp_pkg::ST_PROGRESS;
      counted = 1'b1;
      want    = '0;
      accepted++;
      // length limit is checked ahead of parsing
      if (off > max_len || off == '1) begin
        st = hrlp_pkg::ST_TOO_LONG;
      end else begin
        case (state)
          PS_LEAD:
            if (c == hrlp_pkg::CH_CR || c == hrlp_pkg::CH_LF || c == hrlp_pkg::CH_SP)
              counted = 1'b0;
            else if (is_upper(c)) begin
              add_letter(c);
              state = PS_METHOD;
            end else st = hrlp_pkg::ST_BAD_REQUEST;
          PS_METHOD:
            if (c == hrlp_pkg::CH_SP) state = PS_PRE_URI;
            else if (is_upper(c)) add_letter(c);
            else st = hrlp_pkg::ST_BAD_METHOD;
          PS_PRE_URI:
            if (c == hrlp_pkg::CH_SLASH) begin
              uri_s = off + 1'b1;
              state = PS_URI;
            end else if (c != hrlp_pkg::CH_SP) st = hrlp_pkg::ST_BAD_REQUEST;
          PS_URI:
            if (c == hrlp_pkg::CH_SP) begin
              uri_e = off;
              state = PS_PRE_PROTO;
            end
          PS_PRE_PROTO:
            if (c == hrlp_pkg::CH_H) state = PS_H;
            else if (c != hrlp_pkg::CH_SP) st = hrlp_pkg::ST_BAD_REQUEST;
          PS_H:   if (c == hrlp_pkg::CH_T) state = PS_HT; else st = hrlp_pkg::ST_BAD_REQUEST;
          PS_HT:  if (c == hrlp_pkg::CH_T) state = PS_HTT; else st = hrlp_pkg::ST_BAD_REQUEST;
          PS_HTT: if (c == hrlp_pkg::CH_P) state = PS_HTTP; else st = hrlp_pkg::ST_BAD_REQUEST;
          PS_HTTP:
            if (c == hrlp_pkg::CH_SLASH) state = PS_MAJ_FIRST;
            else st = hrlp_pkg::ST_BAD_REQUEST;
          PS_MAJ_FIRST:
            if (is_digit(c)) begin
              major = hrlp_pkg::VER_W'(c - hrlp_pkg::CH_0);
              state = PS_MAJ;
            end else st = hrlp_pkg::ST_BAD_REQUEST;
          PS_MAJ:
            if (c == hrlp_pkg::CH_DOT) state = PS_MIN_FIRST;
            else if (is_digit(c)) major = add_digit(major, c);
            else st = hrlp_pkg::ST_BAD_REQUEST;
          PS_MIN_FIRST:
            if (is_digit(c)) begin
              minor = hrlp_pkg::VER_W'(c - hrlp_pkg::CH_0);
              state = PS_MIN;
            end else st = hrlp_pkg::ST_BAD_REQUEST;
          PS_MIN, PS_TRAIL:
            if (c == hrlp_pkg::CH_SP) state = PS_TRAIL;
            else if (c == hrlp_pkg::CH_CR) begin
              line_e  = off;
              cr_seen = 1'b1;
              state   = PS_CR;
            end else if (c == hrlp_pkg::CH_LF) begin
              line_e = off;
              st     = hrlp_pkg::ST_DONE;
            end else if (state == PS_MIN && is_digit(c)) minor = add_digit(minor, c);
            else st = hrlp_pkg::ST_BAD_REQUEST;
          PS_CR:
            if (c == hrlp_pkg::CH_LF && cr_seen) st = hrlp_pkg::ST_DONE;
            else st = hrlp_pkg::ST_BAD_REQUEST;
          default: st = hrlp_pkg::ST_BAD_REQUEST;
        endcase
      end
      want.status = st;
      if (st == hrlp_pkg::ST_DONE) begin
        want.method_code   = method_of();
        want.major_version = major;
        want.minor_version = minor;
        want.uri_start     = uri_s;
        want.uri_end       = uri_e;
        want.line_end      = line_e;
      end
      status_seen[st]++;
      expected_q.push_back(want);
      if (st != hrlp_pkg::ST_PROGRESS) restart();
      else if (counted) offset = off + 1'b1;
    endfunction

    function void check_result(logic [hrlp_pkg::OUT_TDATA_W-1:0] word);
      hrlp_pkg::result_t got;
      hrlp_pkg::result_t want;
      string             bad;
      got = word[$bits(hrlp_pkg::result_t)-1:0];
      checked++;
      if (expected_q.size() == 0) begin
        fail($sformatf("record with nothing outstanding: %s", show(got)));
        return;
      end
      want = expected_q.pop_front();
      bad  = "";
      if (got.status !== want.status) bad = {bad, " status"};
      if (got.method_code !== want.method_code) bad = {bad, " method_code"};
      if (got.major_version !== want.major_version) bad = {bad, " major_version"};
      if (got.minor_version !== want.minor_version) bad = {bad, " minor_version"};
      if (got.uri_start !== want.uri_start) bad = {bad, " uri_start"};
      if (got.uri_end !== want.uri_end) bad = {bad, " uri_end"};
      if (got.line_end !== want.line_end) bad = {bad, " line_end"};
      if (word[hrlp_pkg::OUT_TDATA_W-1:$bits(hrlp_pkg::result_t)] !== '0)
        bad = {bad, " padding"};
      if (bad != "")
        fail($sformatf("record %0d wrong:%s\n  expected %s\n  actual   %s",
                       checked, bad, show(want), show(got)));
    endfunction
  endclass

  logic                              clk_i = 1'b0;
  logic                              rst_ni;
  logic                              s_axis_tvalid;
  logic                              s_axis_tready;
  logic [hrlp_pkg::DATA_W-1:0]       s_axis_tdata;   // [7:0] data_byte
  logic                              m_axis_tvalid;
  logic                              m_axis_tready;
  // [2:0] status, [4:3] method_code, [14:5] major, [24:15] minor,
  // [40:25] uri_start, [56:41] uri_end, [72:57] line_end, [79:73] zero
  logic [hrlp_pkg::OUT_TDATA_W-1:0]  m_axis_tdata;
  logic                              psel;
  logic                              penable;
  logic                              pwrite;
  logic [hrlp_pkg::APB_ADDR_W-1:0]   paddr;
  logic [31:0]                       pwdata;
  logic [31:0]                       prdata;
  logic                              pready;

  request_line_scoreboard  sb = new();
  logic [7:0]              tx_q[$];
  int unsigned             bytes_pushed = 0;
  int unsigned             src_idle_pct = 18;
  int unsigned             snk_idle_pct = 48;
  int unsigned             holds_asked  = 0;
  logic [7:0]              blanks[3] = '{hrlp_pkg::CH_CR, hrlp_pkg::CH_LF, hrlp_pkg::CH_SP};

  http_request_line_parser #(.OFFSET_BITS(OFS_W)) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    #20_000_000;
    $display("status: fail");
    $finish;
  end

  // input side: offers queued bytes, notes each transaction with the scoreboard
  initial begin : byte_source
    bit fire;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    forever begin
      @(negedge clk_i);
      fire = rst_ni && s_axis_tvalid && s_axis_tready;
      @(posedge clk_i);
      if (fire) sb.note_byte(s_axis_tdata);
      if (fire || !s_axis_tvalid) begin
        if (tx_q.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= tx_q.pop_front();
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // output side ready, with long hold-offs on request
  initial begin : result_sink
    int unsigned holds_done;
    int unsigned hold_left;
    holds_done = 0;
    hold_left  = 0;
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_left == 0 && holds_done != holds_asked) begin
        holds_done++;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        m_axis_tready <= 1'b0;
        hold_left--;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= snk_idle_pct);
      end
    end
  end

  initial begin : result_monitor
    logic [hrlp_pkg::OUT_TDATA_W-1:0] word;
    forever begin
      @(negedge clk_i);
      if (rst_ni && m_axis_tvalid && m_axis_tready) begin
        word = m_axis_tdata;
        @(posedge clk_i);
        sb.check_result(word);
      end
    end
  end

  task automatic queue_byte(input logic [7:0] b);
    while (tx_q.size() >= TX_DEPTH) @(posedge clk_i);
    tx_q.push_back(b);
    bytes_pushed++;
  endtask

  task automatic queue_text(input string s);
    for (int i = 0; i < s.len(); i++) queue_byte(s[i]);
  endtask

  // mostly well-formed request lines with random content; optionally one byte smashed
  task automatic queue_request(input bit corrupt);
    logic [7:0]  line[$];
    logic [7:0]  b;
    int unsigned kind;
    string       m;
    repeat ($urandom_range(2)) line.push_back(blanks[$urandom_range(2)]);
    kind = $urandom_range(5);
    case (kind)
      0: m = "GET";
      1: m = "HEAD";
      2: m = "POST";
      default: m = "";
    endcase
    for (int i = 0; i < m.len(); i++) line.push_back(m[i]);
    if (kind >= 3)
      repeat ((kind == 3) ? 3 : (kind == 4) ? 4 : $urandom_range(1, 7))
        line.push_back(8'(hrlp_pkg::CH_A + $urandom_range(25)));
    repeat ($urandom_range(1, 2)) line.push_back(hrlp_pkg::CH_SP);
    line.push_back(hrlp_pkg::CH_SLASH);
    repeat ($urandom_range(8)) begin
      b = ($urandom_range(4) == 0) ? 8'($urandom_range(255)) : 8'("a" + $urandom_range(25));
      if (b == hrlp_pkg::CH_SP) b = hrlp_pkg::CH_SLASH;
      line.push_back(b);
    end
    repeat ($urandom_range(1, 2)) line.push_back(hrlp_pkg::CH_SP);
    line.push_back(hrlp_pkg::CH_H);
    line.push_back(hrlp_pkg::CH_T);
    line.push_back(hrlp_pkg::CH_T);
    line.push_back(hrlp_pkg::CH_P);
    line.push_back(hrlp_pkg::CH_SLASH);
    repeat ($urandom_range(1, 4)) line.push_back(8'(hrlp_pkg::CH_0 + $urandom_range(9)));
    line.push_back(hrlp_pkg::CH_DOT);
    repeat ($urandom_range(1, 4)) line.push_back(8'(hrlp_pkg::CH_0 + $urandom_range(9)));
    repeat ($urandom_range(2)) line.push_back(hrlp_pkg::CH_SP);
    if ($urandom_range(1)) line.push_back(hrlp_pkg::CH_CR);
    line.push_back(hrlp_pkg::CH_LF);
    if (corrupt) line[$urandom_range(line.size() - 1)] = 8'($urandom_range(255));
    foreach (line[i]) queue_byte(line[i]);
  endtask

  task automatic run_random(input int unsigned upto);
    int unsigned pick;
    while (bytes_pushed < upto) begin
      pick = $urandom_range(99);
      if (pick < 75) queue_request(1'b0);
      else if (pick < 90) queue_request(1'b1);
      else repeat ($urandom_range(1, 6)) queue_byte(8'($urandom_range(255)));
    end
  endtask

  // every byte handed over and every record back, then the pipeline latency
  task automatic wait_idle();
    while (sb.accepted != bytes_pushed || sb.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic apb_cycle(input bit wr, input logic [31:0] wdata,
                           output logic [31:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= MAX_LEN_ADDR;
    pwdata  <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    while (!pready) @(negedge clk_i);
    rdata = prdata;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_max_len(input logic [hrlp_pkg::LEN_W-1:0] v);
    logic [31:0] rd;
    apb_cycle(1'b1, {16'd0, v}, rd);
    sb.max_len = v;
    apb_cycle(1'b0, '0, rd);
    if (rd !== {16'd0, v})
      sb.fail($sformatf("max_line_length reads %0d, expected %0d", rd, v));
  endtask

  initial begin : stimulus
    logic [31:0]                rd;
    logic [hrlp_pkg::LEN_W-1:0] mid_len;
    rst_ni = 1'b0;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= '0;
    pwdata  <= '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    apb_cycle(1'b0, '0, rd);
    if (rd !== {16'd0, hrlp_pkg::MAX_LINE_LEN_RST})
      sb.fail($sformatf("max_line_length after reset reads %0d, expected %0d",
                        rd, hrlp_pkg::MAX_LINE_LEN_RST));

    // directed lines at the reset limit
    queue_text("\015\n GET / HTTP/1.1\015\n");
    queue_text("HEAD /index HTTP/999.0  \n");
    queue_text("POST  /a\015\nb  HTTP/1000.12345\015\n");
    queue_text("PUT / HTTP/0.0\n");
    queue_text("OPTIONS /x HTTP/2.0\n");
    queue_byte(8'h00);
    queue_byte(8'hFF);
    queue_text("GeT");
    queue_text("GET x");
    queue_text("GET / HTTP/1.1\015X");
    queue_text("GET / HTXP");
    run_random(450);
    wait_idle();

    // tightest limit; long output stall, then a drain pause
    set_max_len(16);
    run_random(620);
    holds_asked++;
    run_random(780);
    wait_idle();
    run_random(900);
    wait_idle();

    src_idle_pct = 48;
    snk_idle_pct = 18;
    mid_len = hrlp_pkg::LEN_W'($urandom_range(17, 96));
    set_max_len(mid_len);
    run_random(1100);
    holds_asked++;
    run_random(1400);
    wait_idle();

    src_idle_pct = 0;
    snk_idle_pct = 0;
    set_max_len(16'hFFFF);
    run_random(1800);
    // space then a NUL restarts the parser from any state
    queue_byte(hrlp_pkg::CH_SP);
    queue_byte(8'h00);
    wait_idle();

    $display("%0d bytes, %0d records: %0d done, %0d bad request, %0d bad method, %0d too long",
             sb.accepted, sb.checked, sb.status_seen[hrlp_pkg::ST_DONE],
             sb.status_seen[hrlp_pkg::ST_BAD_REQUEST],
             sb.status_seen[hrlp_pkg::ST_BAD_METHOD], sb.status_seen[hrlp_pkg::ST_TOO_LONG]);
    $display("line limits 8192, 16, %0d, 65535; two long output stalls, three idle mixes",
             mid_len);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("status: pass");
    end else begin
      $display("%0d mismatches", sb.errors);
      $display("status: fail");
    end
    $finish;
  end

endmodule

// File: http_request_line_parser.f
rtl/hrlp_pkg.sv
rtl/hrlp_cfg.sv
rtl/hrlp_core.sv
rtl/http_request_line_parser.sv
tb/sv/http_request_line_parser_tb.sv
